// ----- hw/rtl/bpit_pkg.sv -----
// Package: types, constants and command structs for the breakpoint table.
`default_nettype none
package bpit_pkg;

  localparam int unsigned NumPointsDef = 11;
  localparam int unsigned IdxW = 4;
  localparam int unsigned ValW = 24;
  localparam int unsigned MaxPoints = 16;
  localparam int unsigned ResetBp = 4;

  typedef logic [1:0] req_t;
  localparam req_t ReqSet = 2'd0;
  localparam req_t ReqClear = 2'd1;
  localparam req_t ReqInit = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t StDone = 2'd0;
  localparam status_t StRange = 2'd1;
  localparam status_t StRefused = 2'd2;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDiv,
    StWrite,
    StDump
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture request, apply mask/value edit
    logic scan_step; // advance the recompute pointer
    logic div_start; // launch divider for current entry
    logic write;     // store computed entry
    logic dump_load; // load output register with current dump entry
    logic dump_step; // advance dump pointer
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic need_div;  // current entry needs an interpolation
    logic scan_done; // recompute pointer past last entry
    logic div_done;
    logic dump_last; // dump pointer on last entry
  } sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/bpit_ctrl.sv -----
// Controller: sequences recompute, divide, write and dump.
`default_nettype none
module bpit_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic           out_busy_i,
  input  wire bpit_pkg::sts_t sts_i,
  output bpit_pkg::cmd_t      cmd_o
);
  import bpit_pkg::*;

  state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_valid_i) state_d = StScan;
      StScan: begin
        if (sts_i.scan_done) state_d = StDump;
        else if (sts_i.need_div) state_d = StDiv;
      end
      StDiv:   if (sts_i.div_done) state_d = StWrite;
      StWrite: state_d = StScan;
      StDump:  if (!out_busy_i && sts_i.dump_last) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StScan: begin
        cmd_o.scan_step = !sts_i.scan_done;
        cmd_o.div_start = !sts_i.scan_done && sts_i.need_div;
      end
      StWrite: cmd_o.write = 1'b1;
      StDump: begin
        cmd_o.dump_load = !out_busy_i;
        cmd_o.dump_step = !out_busy_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end
endmodule
`default_nettype wire

// ----- hw/rtl/bpit_div.sv -----
// Divider: restoring, one quotient bit per cycle, rounds half away from zero.
`default_nettype none
module bpit_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        neg_i,
  input  wire logic [28:0] num_i, // magnitude of numerator
  input  wire logic [4:0]  den_i,
  output logic             done_o,
  output logic signed [25:0] quo_o
);
  import bpit_pkg::*;

  logic [28:0] num_q;
  logic [29:0] rem_q;
  logic [4:0]  den_q;
  logic [4:0]  cnt_q;
  logic        busy_q, neg_q;
  logic [29:0] trial;
  logic [29:0] rem_sh;
  logic [25:0] mag;

  // Shift-subtract one numerator bit per step; rounding added up front.
  assign rem_sh = {rem_q[28:0], num_q[28]};
  assign trial = rem_sh - {25'd0, den_q};
  assign done_o = busy_q && (cnt_q == 5'd0);
  assign mag = num_q[25:0];
  assign quo_o = neg_q ? -$signed(mag) : $signed(mag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q <= 5'd29;
    end else if (busy_q) begin
      if (cnt_q == 5'd0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i + {25'd0, den_i[4:1]};
      den_q <= den_i;
      rem_q <= '0;
      neg_q <= neg_i;
    end else if (busy_q && cnt_q != 5'd0) begin
      if (!trial[29]) begin
        rem_q <= trial;
        num_q <= {num_q[27:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        num_q <= {num_q[27:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/bpit_dp.sv -----
// Datapath: table, mask, gap recompute and dump output register.
`default_nettype none
module bpit_dp #(
  parameter int unsigned NumPoints = bpit_pkg::NumPointsDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [1:0]      req_type_i,
  input  wire logic [3:0]      point_index_i,
  input  wire logic [23:0]     point_value_i,
  input  wire bpit_pkg::cmd_t  cmd_i,
  output bpit_pkg::sts_t       sts_o,
  input  wire logic            out_ready_i,
  output logic                 out_valid_o,
  output logic [3:0]           entry_index_o,
  output logic [23:0]          entry_value_o,
  output logic                 entry_is_breakpoint_o,
  output logic [1:0]           op_status_o,
  output logic                 last_entry_o
);
  import bpit_pkg::*;

  localparam logic [3:0] LastIdx = 4'(NumPoints - 1);

  logic signed [ValW-1:0] vals_q [NumPoints];
  logic [NumPoints-1:0] mask_q;
  status_t st_q;
  logic [3:0] k_q;       // recompute pointer
  logic [3:0] dk_q;      // dump pointer
  logic [4:0] kcnt_q;    // recompute pointer with terminal count
  logic [3:0] lo_q;      // last breakpoint seen
  logic       have_lo_q;
  logic signed [ValW-1:0] lo_val_q;
  logic div_done;
  logic signed [25:0] quo;

  // Find next breakpoint above k: priority over at most 16 bits.
  logic [3:0] nxt;
  logic       have_nxt;
  always_comb begin
    nxt = '0;
    have_nxt = 1'b0;
    for (int j = NumPoints - 1; j >= 0; j--) begin
      if (mask_q[j] && 4'(j) > k_q) begin
        nxt = 4'(j);
        have_nxt = 1'b1;
      end
    end
  end

  logic cur_bp;
  assign cur_bp = mask_q[k_q];
  assign sts_o.scan_done = kcnt_q[4];
  assign sts_o.need_div = !cur_bp && have_lo_q && have_nxt;
  assign sts_o.div_done = div_done;
  assign sts_o.dump_last = (dk_q == LastIdx);

  // Divider inputs: (k-L)*(vR-vL) over (R-L).
  logic signed [24:0] diff;
  logic signed [29:0] prod;
  logic [3:0] kl;
  assign diff = 25'(vals_q[nxt]) - 25'(lo_val_q);
  assign kl = k_q - lo_q;
  assign prod = 30'(diff) * $signed({26'd0, kl});

  bpit_div u_div (
    .clk_i, .rst_ni,
    .start_i(cmd_i.div_start),
    .neg_i  (prod[29]),
    .num_i  (prod[29] ? 29'(-prod) : prod[28:0]),
    .den_i  ({1'b0, nxt - lo_q}),
    .done_o (div_done),
    .quo_o  (quo)
  );

  // Saturated interpolated value.
  logic signed [26:0] sum;
  logic signed [ValW-1:0] ival;
  assign sum = 27'(lo_val_q) + 27'(quo);
  always_comb begin
    if (sum > 27'sd8388607) ival = 24'sh7FFFFF;
    else if (sum < -27'sd8388608) ival = 24'sh800000;
    else ival = sum[23:0];
  end

  // Edit stage, scan and write.
  logic clr_ok;
  logic [NumPoints-1:0] bit_m;
  assign bit_m = NumPoints'(1) << point_index_i;
  assign clr_ok = mask_q[point_index_i] && (mask_q != bit_m);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= NumPoints'(1) << ResetBp;
      kcnt_q <= 5'h10;
      st_q <= StDone;
      for (int j = 0; j < NumPoints; j++) vals_q[j] <= '0;
    end else if (cmd_i.load) begin
      st_q <= StDone;
      kcnt_q <= 5'h10;
      if (req_type_i == ReqSet || req_type_i == ReqClear) begin
        if (point_index_i > LastIdx) st_q <= StRange;
        else if (req_type_i == ReqSet) begin
          mask_q <= mask_q | bit_m;
          vals_q[point_index_i] <= point_value_i;
          kcnt_q <= '0;
        end else if (!clr_ok) st_q <= StRefused;
        else begin
          mask_q <= mask_q & ~bit_m;
          kcnt_q <= '0;
        end
      end else if (req_type_i == ReqInit) begin
        mask_q <= NumPoints'(1) << ResetBp;
        for (int j = 0; j < NumPoints; j++) vals_q[j] <= point_value_i;
      end
    end else begin
      if (cmd_i.write) vals_q[k_q] <= ival;
      if (cmd_i.scan_step && !cmd_i.div_start) begin
        if (!cur_bp && !have_lo_q) vals_q[k_q] <= vals_q[nxt];
        else if (!cur_bp && !have_nxt) vals_q[k_q] <= lo_val_q;
      end
      if ((cmd_i.scan_step && !cmd_i.div_start) || cmd_i.write) begin
        if (kcnt_q == 5'(LastIdx)) kcnt_q <= 5'h10;
        else kcnt_q <= kcnt_q + 5'd1;
      end
    end
  end

  assign k_q = kcnt_q[3:0];

  // Track last breakpoint seen during the scan.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) have_lo_q <= 1'b0;
    else if (cmd_i.load) have_lo_q <= 1'b0;
    else if (cmd_i.scan_step && !cmd_i.div_start && cur_bp) have_lo_q <= 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step && !cmd_i.div_start && cur_bp) begin
      lo_q <= k_q;
      lo_val_q <= vals_q[k_q];
    end
  end

  // Dump pointer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dk_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (cmd_i.load) dk_q <= '0;
      else if (cmd_i.dump_step) begin
        out_valid_o <= 1'b1;
        dk_q <= (dk_q == LastIdx) ? '0 : dk_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dump_load) begin
      entry_index_o <= dk_q;
      entry_value_o <= vals_q[dk_q];
      entry_is_breakpoint_o <= mask_q[dk_q];
      op_status_o <= st_q;
      last_entry_o <= (dk_q == LastIdx);
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/breakpoint_interpolation_table.sv -----
// A successful set or clear runs a recompute scan; each entry between two breakpoints goes
// through the bit-serial divider before it is written, and then the table is dumped.
// One request at a time: a new request is taken only once the dump is done, and the dump
//   waits while the output stalls.
// Reset: table all zero, only point 4 is a breakpoint, no output pending.
// Top level: breakpoint table with piecewise linear gap fill.
`default_nettype none
module breakpoint_interpolation_table #(
  parameter int unsigned NumPoints = bpit_pkg::NumPointsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata, // point_index[3:0], point_value[27:4], pad
  input  wire logic [1:0]  s_axis_tuser, // req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata, // entry_index[3:0], entry_value[27:4],
                                         // entry_is_breakpoint[28], pad
  output logic [1:0]       m_axis_tuser, // op_status
  output logic             m_axis_tlast  // last_entry
);
  import bpit_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [3:0]  eidx;
  logic [23:0] eval;
  logic        ebp;

  bpit_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .out_busy_i(m_axis_tvalid && !m_axis_tready),
    .sts_i(sts),
    .cmd_o(cmd)
  );

  bpit_dp #(.NumPoints(NumPoints)) u_dp (
    .clk_i, .rst_ni,
    .req_type_i(s_axis_tuser),
    .point_index_i(s_axis_tdata[3:0]),
    .point_value_i(s_axis_tdata[27:4]),
    .cmd_i(cmd),
    .sts_o(sts),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .entry_index_o(eidx),
    .entry_value_o(eval),
    .entry_is_breakpoint_o(ebp),
    .op_status_o(m_axis_tuser),
    .last_entry_o(m_axis_tlast)
  );

  assign m_axis_tdata = {3'd0, ebp, eval, eidx};

`ifndef SYNTH
  // Requests are only taken while no dump is in flight.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !cmd.dump_step) else $error("accept during dump");
  // The divider is never launched while a dump is running.
  a_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !cmd.dump_load) else $error("divide during dump");
`endif
endmodule
`default_nettype wire

// ----- sim/tb_breakpoint_interpolation_table.sv -----
// Testbench: random and directed requests against a table predictor, dump checked per entry.
`default_nettype none
module tb_breakpoint_interpolation_table;
  timeunit 1ns;
  timeprecision 1ps;
  import bpit_pkg::*;

  localparam int NP = NumPointsDef;
  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic [1:0]  req;
    logic [3:0]  idx;
    logic [23:0] val;
  } req_item_t;

  typedef struct packed {
    logic [3:0]  idx;
    logic [23:0] val;
    logic        bp;
    logic [1:0]  st;
    logic        last;
  } entry_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic m_axis_tlast;

  breakpoint_interpolation_table #(.NumPoints(NP)) dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always #5 clk_i = ~clk_i;

  req_item_t pending_reqs[$];
  entry_t    dump_expect[$];
  logic signed [23:0] tbl[NP];
  logic [NP-1:0] bp_mask;
  int errors = 0;
  int idle_cycles = 0;
  int hold_off = 0;

  // Rounded interpolation of entries strictly between breakpoints lo and hi.
  function automatic void fill_gap(int lo, int hi);
    longint a, diff, den, n, q;
    a = tbl[lo];
    diff = longint'(tbl[hi]) - a;
    den = hi - lo;
    for (int k = lo + 1; k < hi; k++) begin
      n = (k - lo) * diff;
      if (n >= 0) q = (n + den / 2) / den;
      else q = -((-n + den / 2) / den);
      q = a + q;
      if (q > 8388607) q = 8388607;
      if (q < -8388608) q = -8388608;
      tbl[k] = q[23:0];
    end
  endfunction

  function automatic int bp_left(int i);
    int j;
    j = i - 1;
    while (j >= 0 && !bp_mask[j]) j--;
    return j;
  endfunction

  function automatic int bp_right(int i);
    int j;
    j = i + 1;
    while (j < NP && !bp_mask[j]) j++;
    return j;
  endfunction

  // Apply one request to the table copy and queue the resulting dump.
  function automatic void predict_table(req_item_t r);
    status_t st;
    int i, j, k;
    logic signed [23:0] v;
    st = StDone;
    i = r.idx;
    v = r.val;
    if (r.req == ReqSet || r.req == ReqClear) begin
      if (i >= NP) st = StRange;
      else if (r.req == ReqSet) begin
        tbl[i] = v;
        bp_mask[i] = 1'b1;
        j = bp_left(i);
        if (j < 0) for (k = 0; k < i; k++) tbl[k] = v;
        else fill_gap(j, i);
        j = bp_right(i);
        if (j >= NP) for (k = i + 1; k < NP; k++) tbl[k] = v;
        else fill_gap(i, j);
      end else if (!bp_mask[i] || bp_mask == (NP'(1) << i)) st = StRefused;
      else begin
        bp_mask[i] = 1'b0;
        j = bp_left(i);
        k = bp_right(i);
        if (j >= 0 && k < NP) fill_gap(j, k);
        else if (j >= 0) for (int m = j + 1; m < NP; m++) tbl[m] = tbl[j];
        else if (k < NP) for (int m = 0; m < k; m++) tbl[m] = tbl[k];
      end
    end else if (r.req == ReqInit) begin
      for (k = 0; k < NP; k++) tbl[k] = v;
      bp_mask = NP'(1) << ResetBp;
    end
    for (k = 0; k < NP; k++)
      dump_expect.push_back('{idx: 4'(k), val: tbl[k], bp: bp_mask[k], st: st,
                              last: (k == NP - 1)});
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
  endfunction

  function automatic logic [23:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'(($urandom_range(0, 64)) - 32);
      default: return 24'($urandom);
    endcase
  endfunction

  // Driver: offer queued requests with random gaps.
  int drv_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_table(pending_reqs.pop_front());
        drv_gap = gap_len();
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (drv_gap > 0) begin
          drv_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {4'b0, pending_reqs[0].val, pending_reqs[0].idx};
          s_axis_tuser <= pending_reqs[0].req;
        end else s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted entry against the oldest expectation.
  int mon_gap = 0;
  int mon_count = 0;
  always @(posedge clk_i) begin
    entry_t exp_e, got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{idx: m_axis_tdata[3:0], val: m_axis_tdata[27:4], bp: m_axis_tdata[28],
                st: m_axis_tuser, last: m_axis_tlast};
        if (dump_expect.size() == 0) begin
          $display("%0t: unexpected entry %h", $time, got);
          errors++;
        end else begin
          exp_e = dump_expect.pop_front();
          if (got.idx !== exp_e.idx) begin
            $display("%0t: index exp %0d got %0d", $time, exp_e.idx, got.idx); errors++;
          end
          if (got.val !== exp_e.val) begin
            $display("%0t: value exp %h got %h", $time, exp_e.val, got.val); errors++;
          end
          if (got.bp !== exp_e.bp) begin
            $display("%0t: bp exp %b got %b", $time, exp_e.bp, got.bp); errors++;
          end
          if (got.st !== exp_e.st) begin
            $display("%0t: status exp %0d got %0d", $time, exp_e.st, got.st); errors++;
          end
          if (got.last !== exp_e.last) begin
            $display("%0t: last exp %b got %b", $time, exp_e.last, got.last); errors++;
          end
        end
        mon_count++;
        mon_gap = gap_len();
        // One long hold-off early in the run so the input backs up.
        if (mon_count == 200) hold_off = 3000;
      end
      if (hold_off > 0) begin
        hold_off--;
        m_axis_tready <= 1'b0;
      end else if (mon_gap > 0) begin
        mon_gap--;
        m_axis_tready <= 1'b0;
      end else m_axis_tready <= 1'b1;
    end
  end

  // Watchdog on cycles with no handshake.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchLimit + hold_off) begin
      $display("** breakpoint_interpolation_table: FAILED **");
      $finish;
    end
  end

  function automatic req_item_t mk(logic [1:0] r, int i, logic [23:0] v);
    return '{req: r, idx: 4'(i), val: v};
  endfunction

  initial begin
    int sel;
    for (int k = 0; k < NP; k++) tbl[k] = '0;
    bp_mask = NP'(1) << ResetBp;
    // Directed: extremes, out of range, refused clears, unused type, one-sided clears.
    pending_reqs.push_back(mk(ReqClear, 4, '0));
    pending_reqs.push_back(mk(ReqClear, 3, '0));
    pending_reqs.push_back(mk(ReqSet, 0, 24'h7FFFFF));
    pending_reqs.push_back(mk(ReqSet, NP - 1, 24'h800000));
    pending_reqs.push_back(mk(ReqSet, 7, 24'h000123));
    pending_reqs.push_back(mk(ReqClear, 4, '0));
    pending_reqs.push_back(mk(ReqClear, 0, '0));
    pending_reqs.push_back(mk(ReqClear, NP - 1, '0));
    pending_reqs.push_back(mk(ReqSet, 15, 24'hFFFFFF));
    pending_reqs.push_back(mk(ReqClear, NP, '0));
    pending_reqs.push_back(mk(2'd3, 5, 24'h555555));
    pending_reqs.push_back(mk(ReqInit, 15, 24'h800000));
    pending_reqs.push_back(mk(ReqSet, 1, 24'h7FFFFF));
    pending_reqs.push_back(mk(ReqSet, 9, 24'h800001));
    pending_reqs.push_back(mk(ReqClear, 1, '0));
    pending_reqs.push_back(mk(ReqClear, 4, '0));
    pending_reqs.push_back(mk(ReqInit, 0, 24'h7FFFFF));
    pending_reqs.push_back(mk(ReqSet, 2, 24'h000003));
    pending_reqs.push_back(mk(ReqSet, 8, 24'hFFFFFD));
    pending_reqs.push_back(mk(ReqInit, 3, 24'h000000));
    // Random: mostly sets and clears in range, some inits, range errors and unused type.
    for (int n = 0; n < 450; n++) begin
      sel = $urandom_range(0, 19);
      if (sel < 10) pending_reqs.push_back(mk(ReqSet, $urandom_range(0, NP - 1), rand_val()));
      else if (sel < 16)
        pending_reqs.push_back(mk(ReqClear, $urandom_range(0, NP - 1), 24'($urandom)));
      else if (sel < 17) pending_reqs.push_back(mk(ReqInit, $urandom_range(0, 15), rand_val()));
      else if (sel < 19)
        pending_reqs.push_back(mk(2'($urandom_range(0, 1)), $urandom_range(NP, 15),
                                  24'($urandom)));
      else pending_reqs.push_back(mk(2'd3, $urandom_range(0, 15), 24'($urandom)));
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_reqs.size() == 0 && !s_axis_tvalid);
    wait (dump_expect.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && dump_expect.size() == 0) begin
      $display("** breakpoint_interpolation_table: PASSED **");
    end else begin
      $display("** breakpoint_interpolation_table: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire
